FILE: design/bfm_pkg.sv
// ----------------------------------------------------------------------------
// bfm_pkg
// Shared types and constants of the bloom filter membership block.
// ----------------------------------------------------------------------------
package bfm_pkg;

   localparam int NB_W      = 17;   // num_bits register and probe positions
   localparam int NH_W      = 6;    // num_hashes register
   localparam int LEN_W     = 11;   // key length in bytes, up to 2047
   localparam int CNT_W     = 32;   // entry count
   localparam int ROW_W     = 32;   // bits per row of the bit store
   localparam int BIT_AW    = 5;    // bit select within a row
   localparam int CSR_W     = 17;   // widest register
   localparam int REG_IDX_W = 1;

   localparam logic [31:0] MIX_M      = 32'h5bd1e995;
   localparam logic [31:0] FIRST_SEED = 32'h9747b28c;

   localparam logic [REG_IDX_W-1:0] REG_NUM_BITS   = 1'b0;
   localparam logic [REG_IDX_W-1:0] REG_NUM_HASHES = 1'b1;

   typedef enum logic [1:0] {
      OP_CHECK   = 2'd0,
      OP_ADD     = 2'd1,
      OP_ADD_NEW = 2'd2,
      OP_CLEAR   = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_BAD   = 2'd2
   } status_type;

   // One classified key, handed from the front to the back
   typedef struct packed {
      opcode_type       opcode;
      logic [LEN_W-1:0] len;
      logic             malformed;
      logic             bank;
   } cmd_type;

   typedef struct packed {
      logic                 wr_en;
      logic [REG_IDX_W-1:0] index;
      logic [CSR_W-1:0]     data;
   } csr_type;

endpackage

FILE: design/bfm_chan_if.sv
// ----------------------------------------------------------------------------
// bfm_chan_if
// Valid/ready channels of the bloom filter membership block.
// ----------------------------------------------------------------------------
interface bfm_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  opcode;
   logic [31:0] key_word;
   logic [2:0]  word_bytes;
   logic        last;

   modport source (output valid, opcode, key_word, word_bytes, last, input ready);
   modport sink   (input valid, opcode, key_word, word_bytes, last, output ready);
endinterface

interface bfm_rsp_if;
   logic        valid;
   logic        ready;
   logic        hit;
   logic        is_new;
   logic [31:0] entry_count;
   logic [1:0]  status;

   modport source (output valid, hit, is_new, entry_count, status, input ready);
   modport sink   (input valid, hit, is_new, entry_count, status, output ready);
endinterface

FILE: design/bfm_front.sv
// ----------------------------------------------------------------------------
// bfm_front
// Takes key words, buffers them in one of two key banks and classifies
// the key when its last word arrives.
// ----------------------------------------------------------------------------
module bfm_front #(
   parameter int MAX_KEY_BYTES = 64,
   parameter int WORD_AW       = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   bfm_req_if.sink               req_chan,
   input  logic                  queue_full,
   input  logic                  init_busy,
   output logic                  cmd_push,
   output bfm_pkg::cmd_type      cmd,
   input  logic [WORD_AW:0]      rd_addr,
   output logic [31:0]           rd_data
);
   import bfm_pkg::*;

   logic [LEN_W-1:0] cnt_ff, cnt_in, cnt_n;
   logic             mal_ff, mal_in, mal_n;
   logic             bank_ff, bank_in;
   logic [LEN_W:0]   sum;
   logic [31:0]      mask;
   logic             wr_en;
   logic             accept;
   logic [WORD_AW:0] wr_addr;
   logic [31:0]      key_mem [2**(WORD_AW+1)];
   logic [31:0]      rd_data_ff;

   assign req_chan.ready = !queue_full && !init_busy;
   assign accept         = req_chan.valid && req_chan.ready;
   assign wr_addr        = {bank_ff, cnt_ff[WORD_AW+1:2]};
   assign rd_data        = rd_data_ff;

   always_comb begin
      sum   = {1'b0, cnt_ff} + {{(LEN_W-2){1'b0}}, req_chan.word_bytes};
      mal_n = mal_ff;
      cnt_n = cnt_ff;
      wr_en = 1'b0;
      unique case (req_chan.word_bytes)
         3'd1:    mask = 32'h0000_00ff;
         3'd2:    mask = 32'h0000_ffff;
         3'd3:    mask = 32'h00ff_ffff;
         default: mask = 32'hffff_ffff;
      endcase
      if (req_chan.word_bytes > 3'd4 || (!req_chan.last && req_chan.word_bytes != 3'd4)) begin
         mal_n = 1'b1;
      end else if (!mal_ff) begin
         if (sum > (LEN_W+1)'(MAX_KEY_BYTES)) begin
            mal_n = 1'b1;
         end else if (req_chan.word_bytes != 3'd0) begin
            wr_en = 1'b1;
            cnt_n = sum[LEN_W-1:0];
         end
      end
      cmd_push      = accept && req_chan.last;
      cmd.opcode    = opcode_type'(req_chan.opcode);
      cmd.len       = cnt_n;
      cmd.malformed = mal_n;
      cmd.bank      = bank_ff;
      cnt_in  = cnt_ff;
      mal_in  = mal_ff;
      bank_in = bank_ff;
      if (accept) begin
         cnt_in = req_chan.last ? '0 : cnt_n;
         mal_in = req_chan.last ? 1'b0 : mal_n;
         // flip to the other bank once the key is queued
         bank_in = req_chan.last ? !bank_ff : bank_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         mal_ff  <= 1'b0;
         bank_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         mal_ff  <= mal_in;
         bank_ff <= bank_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && wr_en) begin
         key_mem[wr_addr] <= req_chan.key_word & mask;
      end
      rd_data_ff <= key_mem[rd_addr];
   end

endmodule

FILE: design/bfm_queue.sv
// ----------------------------------------------------------------------------
// bfm_queue
// Two-entry command queue between front and back; one entry per key bank.
// ----------------------------------------------------------------------------
module bfm_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  bfm_pkg::cmd_type push_data,
   input  logic             pop,
   output bfm_pkg::cmd_type head,
   output logic             empty,
   output logic             full
);
   import bfm_pkg::*;

   cmd_type    entry_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] fill_ff;

   assign head  = entry_ff[rd_ptr_ff];
   assign empty = (fill_ff == 2'd0);
   assign full  = (fill_ff == 2'd2);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= !wr_ptr_ff;
         if (pop)  rd_ptr_ff <= !rd_ptr_ff;
         fill_ff <= fill_ff + {1'b0, push} - {1'b0, pop};
      end
   end

   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= push_data;
   end

endmodule

FILE: design/bfm_hash.sv
// ----------------------------------------------------------------------------
// bfm_hash
// MurmurHash2 over the buffered key, one shared multiplier by the mix
// constant, registered after every multiply.
// ----------------------------------------------------------------------------
module bfm_hash #(
   parameter int WORD_AW = 4
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [31:0]               seed,
   input  logic [bfm_pkg::LEN_W-1:0] len,
   output logic [WORD_AW-1:0]        word_addr,
   input  logic [31:0]               rd_data,
   output logic                      done,
   output logic [31:0]               hash
);
   import bfm_pkg::*;

   typedef enum logic [9:0] {
      H_IDLE = 10'b00_0000_0001,
      H_ADDR = 10'b00_0000_0010,
      H_K1   = 10'b00_0000_0100,
      H_K2   = 10'b00_0000_1000,
      H_K3   = 10'b00_0001_0000,
      H_K4   = 10'b00_0010_0000,
      H_TAIL = 10'b00_0100_0000,
      H_T2   = 10'b00_1000_0000,
      H_F1   = 10'b01_0000_0000,
      H_F2   = 10'b10_0000_0000
   } hash_state_type;

   hash_state_type   state_ff, state_in;
   logic [31:0]      h_ff, h_in, k_ff, k_in, prod_ff, mul_a;
   logic [LEN_W-1:0] pos_ff, pos_in, rest_ff, rest_in;
   logic             done_ff, done_in;

   assign word_addr = pos_ff[WORD_AW+1:2];
   assign done      = done_ff;
   assign hash      = h_ff;

   always_comb begin
      state_in = state_ff;
      h_in     = h_ff;
      k_in     = k_ff;
      pos_in   = pos_ff;
      rest_in  = rest_ff;
      done_in  = 1'b0;
      mul_a    = h_ff;
      unique case (state_ff)
         H_IDLE: begin
            if (start) begin
               h_in     = seed ^ {{(32-LEN_W){1'b0}}, len};
               pos_in   = '0;
               rest_in  = len;
               state_in = H_ADDR;
            end
         end
         H_ADDR: begin
            if (rest_ff >= LEN_W'(4))      state_in = H_K1;
            else if (rest_ff != '0)        state_in = H_TAIL;
            else                           state_in = H_F1;
         end
         H_K1: mul_a = rd_data;
         H_K2: mul_a = prod_ff ^ (prod_ff >> 24);
         H_K3: begin
            k_in  = prod_ff;
            mul_a = h_ff;
         end
         H_K4: begin
            h_in    = prod_ff ^ k_ff;
            pos_in  = pos_ff + LEN_W'(4);
            rest_in = rest_ff - LEN_W'(4);
         end
         H_TAIL: mul_a = h_ff ^ rd_data;
         H_T2:   h_in = prod_ff;
         H_F1:   mul_a = h_ff ^ (h_ff >> 13);
         H_F2: begin
            h_in    = prod_ff ^ (prod_ff >> 15);
            done_in = 1'b1;
         end
         default: state_in = H_IDLE;
      endcase
      unique case (state_ff)
         H_K1:    state_in = H_K2;
         H_K2:    state_in = H_K3;
         H_K3:    state_in = H_K4;
         H_K4:    state_in = H_ADDR;
         H_TAIL:  state_in = H_T2;
         H_T2:    state_in = H_F1;
         H_F1:    state_in = H_F2;
         H_F2:    state_in = H_IDLE;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= H_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      h_ff    <= h_in;
      k_ff    <= k_in;
      pos_ff  <= pos_in;
      rest_ff <= rest_in;
      prod_ff <= mul_a * MIX_M;
   end

endmodule

FILE: design/bfm_div.sv
// ----------------------------------------------------------------------------
// bfm_div
// Restoring remainder unit: 32-bit dividend by a 17-bit modulus, one
// quotient bit per cycle.
// ----------------------------------------------------------------------------
module bfm_div (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [31:0]              dividend,
   input  logic [bfm_pkg::NB_W-1:0] divisor,
   output logic                     done,
   output logic [bfm_pkg::NB_W-1:0] rem
);
   import bfm_pkg::*;

   logic [31:0]     q_ff;
   logic [NB_W-1:0] r_ff, d_ff;
   logic [NB_W:0]   trial;
   logic [5:0]      step_ff;
   logic            busy_ff, done_ff;

   assign trial = {r_ff, q_ff[31]};
   assign done  = done_ff;
   assign rem   = r_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (!busy_ff && start) begin
            busy_ff <= 1'b1;
            step_ff <= 6'd0;
         end else if (busy_ff) begin
            step_ff <= step_ff + 6'd1;
            if (step_ff == 6'd31) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!busy_ff && start) begin
         q_ff <= dividend;
         d_ff <= divisor;
         r_ff <= '0;
      end else if (busy_ff) begin
         q_ff <= q_ff << 1;
         if (trial >= {1'b0, d_ff}) r_ff <= NB_W'(trial - {1'b0, d_ff});
         else                       r_ff <= trial[NB_W-1:0];
      end
   end

endmodule

FILE: design/bfm_back.sv
// ----------------------------------------------------------------------------
// bfm_back
// Runs one queued key: two hash passes, three remainders, then the probe
// walk over the bit store; also the clearing sweep and the result register.
// ----------------------------------------------------------------------------
module bfm_back #(
   parameter int FILTER_BITS = 65536,
   parameter int MAX_PROBES  = 32,
   parameter int WORD_AW     = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  bfm_pkg::csr_type csr,
   input  bfm_pkg::cmd_type head,
   input  logic             q_empty,
   output logic             pop,
   output logic             init_busy,
   output logic [WORD_AW:0] key_addr,
   input  logic [31:0]      key_data,
   bfm_rsp_if.source        rsp_chan
);
   import bfm_pkg::*;

   localparam int ROWS    = (FILTER_BITS + ROW_W - 1) / ROW_W;
   localparam int ROW_AW  = $clog2(ROWS);
   localparam int PROBE_W = $clog2(MAX_PROBES + 1);

   typedef enum logic [10:0] {
      B_INIT  = 11'b000_0000_0001,
      B_IDLE  = 11'b000_0000_0010,
      B_HA    = 11'b000_0000_0100,
      B_HB    = 11'b000_0000_1000,
      B_DA    = 11'b000_0001_0000,
      B_DB    = 11'b000_0010_0000,
      B_DC    = 11'b000_0100_0000,
      B_RD    = 11'b000_1000_0000,
      B_CHK   = 11'b001_0000_0000,
      B_CLEAR = 11'b010_0000_0000,
      B_OUT   = 11'b100_0000_0000
   } back_state_type;

   back_state_type     state_ff, state_in;
   logic [NB_W-1:0]    num_bits_ff;
   logic [NH_W-1:0]    num_hashes_ff;
   logic [31:0]        nb32, a_ff, a_in, b_ff, b_in, s_ff, s_in, x32;
   logic [NB_W-1:0]    nb_eff, x_ff, x_in, bm_ff, bm_in, c_ff, c_in;
   logic [7:0]         nh8;
   logic [PROBE_W-1:0] nh_eff, i_ff, i_in;
   logic               all_ff, all_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               res_hit_ff, res_hit_in, res_new_ff, res_new_in;
   status_type         res_st_ff, res_st_in;
   logic [CNT_W-1:0]   res_cnt_ff, res_cnt_in;
   logic [ROW_AW-1:0]  row_ff, row_in, x_row;
   logic [ROW_W-1:0]   store [ROWS];
   logic [ROW_W-1:0]   row_data_ff, st_wdata;
   logic               st_we;
   logic [ROW_AW-1:0]  st_waddr;
   logic               hash_start, hash_done, div_start, div_done;
   logic [31:0]        hash_seed, hash_out, div_dividend;
   logic [NB_W-1:0]    div_rem;
   logic [WORD_AW-1:0] hash_word;
   logic [NB_W:0]      t1, t2, c_sum;
   logic [32:0]        s_sum;
   logic               probe_bit, is_add, last_probe, hit_v, finish, rsp_load;
   logic               rsp_valid_ff;

   bfm_hash #(.WORD_AW(WORD_AW)) u_hash (
      .clock     (clock),
      .reset     (reset),
      .start     (hash_start),
      .seed      (hash_seed),
      .len       (head.len),
      .word_addr (hash_word),
      .rd_data   (key_data),
      .done      (hash_done),
      .hash      (hash_out)
   );

   bfm_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (nb_eff),
      .done     (div_done),
      .rem      (div_rem)
   );

   assign key_addr  = {head.bank, hash_word};
   assign init_busy = (state_ff == B_INIT);

   // clamp the registers into their working ranges
   always_comb begin
      nb32 = {{(32-NB_W){1'b0}}, num_bits_ff};
      if (nb32 == 32'd0)                 nb32 = 32'd1;
      else if (nb32 > 32'(FILTER_BITS))  nb32 = 32'(FILTER_BITS);
      nb_eff = nb32[NB_W-1:0];
      nh8 = {2'b00, num_hashes_ff};
      if (nh8 == 8'd0)                   nh8 = 8'd1;
      else if (nh8 > 8'(MAX_PROBES))     nh8 = 8'(MAX_PROBES);
      nh_eff = nh8[PROBE_W-1:0];
   end

   assign x32   = {{(32-NB_W){1'b0}}, x_ff};
   assign x_row = x32[ROW_AW+BIT_AW-1:BIT_AW];

   // next probe position: x + (b mod n), less (2^32 mod n) when the sum wraps
   always_comb begin
      s_sum = {1'b0, s_ff} + {1'b0, b_ff};
      t1    = {1'b0, x_ff} + {1'b0, bm_ff};
      if (t1 >= {1'b0, nb_eff}) t1 = t1 - {1'b0, nb_eff};
      t2 = t1;
      if (s_sum[32]) begin
         if (t1[NB_W-1:0] >= c_ff) t2 = t1 - {1'b0, c_ff};
         else                      t2 = t1 + {1'b0, nb_eff} - {1'b0, c_ff};
      end
      c_sum = {1'b0, div_rem} + {{NB_W{1'b0}}, 1'b1};
   end

   assign probe_bit  = row_data_ff[x_ff[BIT_AW-1:0]];
   assign is_add     = (head.opcode != OP_CHECK);
   assign last_probe = ((i_ff + PROBE_W'(1)) == nh_eff);
   assign rsp_load   = (state_ff == B_OUT) && (!rsp_valid_ff || rsp_chan.ready);

   always_comb begin
      state_in     = state_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      s_in         = s_ff;
      x_in         = x_ff;
      bm_in        = bm_ff;
      c_in         = c_ff;
      i_in         = i_ff;
      all_in       = all_ff;
      row_in       = row_ff;
      count_in     = count_ff;
      res_hit_in   = res_hit_ff;
      res_new_in   = res_new_ff;
      res_st_in    = res_st_ff;
      res_cnt_in   = res_cnt_ff;
      hash_start   = 1'b0;
      hash_seed    = FIRST_SEED;
      div_start    = 1'b0;
      div_dividend = a_ff;
      st_we        = 1'b0;
      st_waddr     = x_row;
      st_wdata     = row_data_ff | (ROW_W'(1) << x_ff[BIT_AW-1:0]);
      pop          = 1'b0;
      hit_v        = 1'b0;
      finish       = 1'b0;
      unique case (state_ff)
         B_INIT, B_CLEAR: begin
            st_we    = 1'b1;
            st_waddr = row_ff;
            st_wdata = '0;
            row_in   = row_ff + ROW_AW'(1);
            if (row_ff == ROW_AW'(ROWS - 1)) begin
               if (state_ff == B_INIT) begin
                  state_in = B_IDLE;
               end else begin
                  count_in   = '0;
                  res_hit_in = 1'b0;
                  res_new_in = 1'b0;
                  res_st_in  = ST_OK;
                  res_cnt_in = '0;
                  state_in   = B_OUT;
               end
            end
         end
         B_IDLE: begin
            res_hit_in = 1'b0;
            res_new_in = 1'b0;
            res_cnt_in = count_ff;
            if (!q_empty) begin
               priority if (head.opcode == OP_CLEAR) begin
                  row_in   = '0;
                  state_in = B_CLEAR;
               end else if (head.malformed) begin
                  res_st_in = ST_BAD;
                  state_in  = B_OUT;
               end else if (head.len == '0) begin
                  res_st_in = ST_EMPTY;
                  state_in  = B_OUT;
               end else begin
                  hash_start = 1'b1;
                  state_in   = B_HA;
               end
            end
         end
         B_HA: begin
            if (hash_done) begin
               a_in       = hash_out;
               hash_start = 1'b1;
               hash_seed  = hash_out;
               state_in   = B_HB;
            end
         end
         B_HB: begin
            if (hash_done) begin
               b_in      = hash_out;
               div_start = 1'b1;
               state_in  = B_DA;
            end
         end
         B_DA: begin
            div_dividend = b_ff;
            if (div_done) begin
               x_in      = div_rem;
               div_start = 1'b1;
               state_in  = B_DB;
            end
         end
         B_DB: begin
            div_dividend = 32'hffff_ffff;
            if (div_done) begin
               bm_in     = div_rem;
               div_start = 1'b1;
               state_in  = B_DC;
            end
         end
         B_DC: begin
            if (div_done) begin
               c_in     = (c_sum == {1'b0, nb_eff}) ? '0 : c_sum[NB_W-1:0];
               s_in     = a_ff;
               i_in     = '0;
               all_in   = 1'b1;
               state_in = B_RD;
            end
         end
         B_RD: state_in = B_CHK;
         B_CHK: begin
            st_we = !probe_bit && is_add;
            priority if (!probe_bit && !is_add) begin
               finish = 1'b1;
               hit_v  = 1'b0;
            end else if (last_probe) begin
               finish = 1'b1;
               hit_v  = all_ff && probe_bit;
            end else begin
               all_in   = all_ff && probe_bit;
               i_in     = i_ff + PROBE_W'(1);
               x_in     = t2[NB_W-1:0];
               s_in     = s_sum[31:0];
               state_in = B_RD;
            end
            if (finish) begin
               if (is_add && !hit_v && count_ff != '1) count_in = count_ff + CNT_W'(1);
               res_hit_in = hit_v;
               res_new_in = is_add && !hit_v;
               res_st_in  = ST_OK;
               res_cnt_in = (is_add && !hit_v && count_ff != '1) ?
                            count_ff + CNT_W'(1) : count_ff;
               state_in   = B_OUT;
            end
         end
         B_OUT: begin
            if (rsp_load) begin
               pop      = 1'b1;
               state_in = B_IDLE;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= B_INIT;
         row_ff        <= '0;
         count_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
         num_bits_ff   <= NB_W'(65536);
         num_hashes_ff <= NH_W'(7);
      end else begin
         state_ff <= state_in;
         row_ff   <= row_in;
         count_ff <= count_in;
         if (rsp_load)                rsp_valid_ff <= 1'b1;
         else if (rsp_chan.ready)     rsp_valid_ff <= 1'b0;
         if (csr.wr_en) begin
            unique case (csr.index)
               REG_NUM_BITS:   num_bits_ff   <= csr.data[NB_W-1:0];
               REG_NUM_HASHES: num_hashes_ff <= csr.data[NH_W-1:0];
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      a_ff       <= a_in;
      b_ff       <= b_in;
      s_ff       <= s_in;
      x_ff       <= x_in;
      bm_ff      <= bm_in;
      c_ff       <= c_in;
      i_ff       <= i_in;
      all_ff     <= all_in;
      res_hit_ff <= res_hit_in;
      res_new_ff <= res_new_in;
      res_st_ff  <= res_st_in;
      res_cnt_ff <= res_cnt_in;
      if (rsp_load) begin
         rsp_chan.hit         <= res_hit_ff;
         rsp_chan.is_new      <= res_new_ff;
         rsp_chan.entry_count <= res_cnt_ff;
         rsp_chan.status      <= res_st_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (st_we) store[st_waddr] <= st_wdata;
      row_data_ff <= store[x_row];
   end

   assign rsp_chan.valid = rsp_valid_ff;

   a_pos_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == B_RD |-> (x_ff < nb_eff && bm_ff < nb_eff && c_ff < nb_eff))
      else $error("probe position or step out of range");

   a_check_no_write: assert property (@(posedge clock) disable iff (reset)
      (st_we && state_ff == B_CHK) |-> head.opcode != OP_CHECK)
      else $error("check wrote the bit store");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_empty)
      else $error("pop from empty queue");

   a_count_kept: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_OUT && $past(state_ff) == B_CHK) |-> count_ff >= $past(count_ff))
      else $error("entry count dropped on add or check");

endmodule

FILE: design/bloom_filter_membership.sv
// ----------------------------------------------------------------------------
// bloom_filter_membership
// Bloom filter with MurmurHash2 double hashing: check, add, add-if-new, clear.
// ----------------------------------------------------------------------------
//  channel   dir  payload                                   accepted when
//  req_chan  in   opcode, key_word, word_bytes, last        valid && ready
//  rsp_chan  out  hit, is_new, entry_count, status          valid && ready
//  csr_*     in   csr_index, csr_wr_data                    csr_wr_en
//
//  Key words enter at one per cycle while req_chan.ready is high; up to
//  two keys wait in the command queue, each in its own key bank, the
//  head being the one the back runs. Per key the back runs two hash passes,
//  three remainder passes and a read and check per probe, then the result.
//  Clear, and the clearing pass after reset, sweep FILTER_BITS / 32 rows at
//  one row per cycle; req_chan.ready stays low during the pass after reset.
//  A waiting result in rsp_chan stalls only the back; the front keeps
//  taking words until both key banks are held.
// ----------------------------------------------------------------------------
module bloom_filter_membership #(
   parameter int FILTER_BITS   = 65536,
   parameter int MAX_KEY_BYTES = 64,
   parameter int MAX_PROBES    = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   bfm_req_if.sink                       req_chan,
   bfm_rsp_if.source                     rsp_chan,
   input  logic                          csr_wr_en,
   input  logic [bfm_pkg::REG_IDX_W-1:0] csr_index,
   input  logic [bfm_pkg::CSR_W-1:0]     csr_wr_data
);
   import bfm_pkg::*;

   localparam int KEY_WORDS = (MAX_KEY_BYTES + 3) / 4;
   localparam int WORD_AW   = (KEY_WORDS > 1) ? $clog2(KEY_WORDS) : 1;

   cmd_type          push_cmd, head_cmd;
   csr_type          csr;
   logic             cmd_push, cmd_pop, q_empty, q_full, init_busy;
   logic [WORD_AW:0] key_addr;
   logic [31:0]      key_data;

   assign csr.wr_en = csr_wr_en;
   assign csr.index = csr_index;
   assign csr.data  = csr_wr_data;

   bfm_front #(
      .MAX_KEY_BYTES (MAX_KEY_BYTES),
      .WORD_AW       (WORD_AW)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .queue_full (q_full),
      .init_busy  (init_busy),
      .cmd_push   (cmd_push),
      .cmd        (push_cmd),
      .rd_addr    (key_addr),
      .rd_data    (key_data)
   );

   bfm_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (push_cmd),
      .pop       (cmd_pop),
      .head      (head_cmd),
      .empty     (q_empty),
      .full      (q_full)
   );

   bfm_back #(
      .FILTER_BITS (FILTER_BITS),
      .MAX_PROBES  (MAX_PROBES),
      .WORD_AW     (WORD_AW)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .csr       (csr),
      .head      (head_cmd),
      .q_empty   (q_empty),
      .pop       (cmd_pop),
      .init_busy (init_busy),
      .key_addr  (key_addr),
      .key_data  (key_data),
      .rsp_chan  (rsp_chan)
   );

endmodule
